@@ hw/rtl/lru_page_replacement_macros.svh @@
// ----------------------------------------------------------------------------
// LRU page replacement assertion macros
// Shared concurrent assertion forms, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_MACROS_SVH

// Assertion that is switched off while reset is asserted
`define LRUP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that must hold in and out of reset
`define LRUP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hw/rtl/lrup_pkg.sv @@
// ----------------------------------------------------------------------------
// lrup_pkg
// Sizes and shared types of the LRU page replacement block.
// ----------------------------------------------------------------------------
package lrup_pkg;

  localparam int FRAMES          = 4;
  localparam int PAGE_BITS       = 8;
  localparam int IDX_W           = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W           = $clog2(FRAMES + 1);
  localparam int AGE_W           = IDX_W;
  localparam int COUNT_W         = 16;
  localparam int CFG_W           = 3;
  localparam int SLOT_W          = 2;
  localparam int FRAMES_USED_RST = 3;

  // Lookup results rippling down the row of frame cells
  typedef struct packed {
    logic                 found;
    logic [IDX_W-1:0]     hit_slot;
    logic [AGE_W-1:0]     hit_age;
    logic                 vic_found;
    logic [IDX_W-1:0]     vic_slot;
    logic [PAGE_BITS-1:0] vic_page;
  } chain_t;

  // Update command broadcast to every frame cell
  typedef struct packed {
    logic                 en;
    logic                 clear;
    logic                 wr_page;
    logic                 age_all;
    logic [AGE_W-1:0]     limit;
    logic [IDX_W-1:0]     slot;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

endpackage

@@ hw/rtl/lru_page_replacement.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement
// LRU page replacement over a row of frame cells.
// ----------------------------------------------------------------------------
// One page reference is taken per clock cycle and its result appears in the
// output register on the next cycle; a new reference is taken whenever that
// register is empty or its result is being transferred in the same cycle.
// The reference is compared against every frame cell at once, and the hit and
// the least recent frame ripple down the row of cells within that cycle, so
// the row length sets the critical path. A write of frames_used flushes all
// frames (counts are kept) and must only be done while the block is idle.
// ----------------------------------------------------------------------------
module lru_page_replacement import lrup_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_W-1:0]     frames_used_i,
  // references
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PAGE_BITS-1:0] page_i,
  // results
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 hit_o,
  output logic [SLOT_W-1:0]    slot_o,
  output logic                 evicted_valid_o,
  output logic [PAGE_BITS-1:0] evicted_page_o,
  output logic [COUNT_W-1:0]   fault_count_o,
  output logic [COUNT_W-1:0]   access_count_o
);

  logic [CFG_W-1:0]   frames_used_q;
  logic [CNT_W-1:0]   filled_q, filled_d, used;
  logic [COUNT_W-1:0] fault_q, fault_d, access_q, access_d;
  logic [AGE_W-1:0]   last_age;
  logic               cfg_xfer, item_xfer, hit, fill, repl;
  logic [IDX_W-1:0]   slot;
  upd_t               upd;
  chain_t             chain [FRAMES+1];

  logic                 out_valid_q, out_valid_d;
  logic                 hit_q, ev_valid_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [PAGE_BITS-1:0] ev_page_q;
  logic [COUNT_W-1:0]   fault_out_q, access_out_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i & cfg_ready_o;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign item_xfer   = in_valid_i & in_ready_o;

  // Frames in use, out of range values clamped
  always_comb begin
    if (frames_used_q == '0) begin
      used = CNT_W'(1);
    end else if (int'(frames_used_q) > FRAMES) begin
      used = CNT_W'(FRAMES);
    end else begin
      used = CNT_W'(frames_used_q);
    end
  end

  assign last_age = AGE_W'(filled_q - 1'b1);

  // Row of frame cells
  assign chain[0] = '0;
  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrup_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .idx_i      (IDX_W'(g)),
      .key_i      (page_i),
      .filled_i   (filled_q),
      .last_age_i (last_age),
      .chain_i    (chain[g]),
      .chain_o    (chain[g+1]),
      .upd_i      (upd)
    );
  end

  // Decide hit, fill or replace
  assign hit  = chain[FRAMES].found;
  assign fill = !hit && (filled_q < used);
  assign repl = !hit && !fill;

  always_comb begin
    if (hit) begin
      slot = chain[FRAMES].hit_slot;
    end else if (fill) begin
      slot = IDX_W'(filled_q);
    end else begin
      slot = chain[FRAMES].vic_slot;
    end
  end

  always_comb begin
    upd.en      = item_xfer && !cfg_xfer;
    upd.clear   = cfg_xfer;
    upd.wr_page = !hit;
    upd.age_all = !hit;
    upd.limit   = chain[FRAMES].hit_age;
    upd.slot    = slot;
    upd.page    = page_i;
  end

  // Fill count and saturating totals
  always_comb begin
    filled_d = filled_q;
    fault_d  = fault_q;
    access_d = access_q;
    if (cfg_xfer) begin
      filled_d = '0;
    end else if (item_xfer && fill) begin
      filled_d = filled_q + 1'b1;
    end
    if (item_xfer) begin
      access_d = (access_q == '1) ? access_q : access_q + 1'b1;
      if (!hit) begin
        fault_d = (fault_q == '1) ? fault_q : fault_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_used_q <= CFG_W'(FRAMES_USED_RST);
      filled_q      <= '0;
      fault_q       <= '0;
      access_q      <= '0;
    end else begin
      if (cfg_xfer) begin
        frames_used_q <= frames_used_i;
      end
      filled_q <= filled_d;
      fault_q  <= fault_d;
      access_q <= access_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (item_xfer) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_xfer) begin
      hit_q        <= hit;
      slot_q       <= SLOT_W'(slot);
      ev_valid_q   <= repl;
      ev_page_q    <= repl ? chain[FRAMES].vic_page : '0;
      fault_out_q  <= fault_d;
      access_out_q <= access_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_o           = hit_q;
  assign slot_o          = slot_q;
  assign evicted_valid_o = ev_valid_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_out_q;
  assign access_count_o  = access_out_q;

endmodule

@@ hw/rtl/lrup_cell.sv @@
// ----------------------------------------------------------------------------
// lrup_cell
// One frame: resident page and recency age, compare and age update.
// ----------------------------------------------------------------------------
module lrup_cell import lrup_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [IDX_W-1:0]     idx_i,
  input  logic [PAGE_BITS-1:0] key_i,
  input  logic [CNT_W-1:0]     filled_i,
  input  logic [AGE_W-1:0]     last_age_i,
  input  chain_t               chain_i,
  output chain_t               chain_o,
  input  upd_t                 upd_i
);

  logic [PAGE_BITS-1:0] page_q;
  logic [AGE_W-1:0]     age_q, age_d;
  logic                 valid, match, is_slot;

  assign valid   = CNT_W'(idx_i) < filled_i;
  assign match   = valid && (page_q == key_i);
  assign is_slot = (idx_i == upd_i.slot);

  // First hit and the oldest frame are claimed by the lowest cell
  always_comb begin
    chain_o = chain_i;
    if (!chain_i.found && match) begin
      chain_o.found    = 1'b1;
      chain_o.hit_slot = idx_i;
      chain_o.hit_age  = age_q;
    end
    if (!chain_i.vic_found && valid && (age_q == last_age_i)) begin
      chain_o.vic_found = 1'b1;
      chain_o.vic_slot  = idx_i;
      chain_o.vic_page  = page_q;
    end
  end

  // Touched frame becomes youngest; younger ones age by one, all filled ones on a miss
  always_comb begin
    age_d = age_q;
    if (upd_i.clear) begin
      age_d = '0;
    end else if (upd_i.en) begin
      if (is_slot) begin
        age_d = '0;
      end else if (valid && (upd_i.age_all || (age_q < upd_i.limit))) begin
        age_d = age_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_q <= '0;
    end else begin
      age_q <= age_d;
    end
  end

  // Page storage, written on fill or replace
  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.wr_page && is_slot) begin
      page_q <= upd_i.page;
    end
  end

endmodule

@@ hw/rtl/lrup_checker.sv @@
// ----------------------------------------------------------------------------
// lrup_checker
// Port level checks of the LRU page replacement block, bound to the top.
// ----------------------------------------------------------------------------
`include "lru_page_replacement_macros.svh"

module lrup_checker import lrup_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_ready_o,
  input logic                 out_valid_o,
  input logic                 hit_o,
  input logic                 evicted_valid_o,
  input logic [PAGE_BITS-1:0] evicted_page_o,
  input logic [COUNT_W-1:0]   fault_count_o,
  input logic [COUNT_W-1:0]   access_count_o
);

  // a hit never replaces a frame
  `LRUP_ASSERT(a_hit_no_evict, out_valid_o && hit_o |-> !evicted_valid_o, "eviction on a hit")

  // no eviction means a zero evicted page
  `LRUP_ASSERT(a_evict_page_zero, out_valid_o && !evicted_valid_o |-> evicted_page_o == '0, "evicted page not zero")

  // faults are a subset of accesses
  `LRUP_ASSERT(a_fault_le_access, out_valid_o |-> fault_count_o <= access_count_o, "fault count above access count")

  // input only stalls behind a pending result
  `LRUP_ASSERT_ALWAYS(a_stall_cause, !in_ready_o |-> out_valid_o, "input stalled with empty output")

endmodule

bind lru_page_replacement lrup_checker u_lrup_checker (.*);

@@ verif/lru_page_replacement_tb.sv @@
// ----------------------------------------------------------------------------
// lru_page_replacement_tb
// Self-checking bench for the LRU page replacement block. A driver replays a
// queue of page references and frames_used writes, a monitor predicts each
// lookup with its own LRU frame table and checks every result in order.
// ----------------------------------------------------------------------------
module lru_page_replacement_tb;
  import lrup_pkg::*;

  localparam int COUNT_MAX   = 65535;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RAND_REFS   = 1750;
  localparam int FAULT_REFS  = 40;

  typedef enum {JOB_REF, JOB_SET_FRAMES, JOB_QUIESCE} job_kind_e;

  // One entry of the stimulus queue
  typedef struct {
    job_kind_e kind;
    int        value;
    int        gap;
    int        stall;
  } job_t;

  // Expected lookup outcome, plus the receiver pause that follows it
  typedef struct {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
    logic [COUNT_W-1:0]   faults;
    logic [COUNT_W-1:0]   accesses;
    int                   rx_stall;
  } ref_outcome_t;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_W-1:0]     frames_used_i = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_ready_o;
  logic [PAGE_BITS-1:0] page_i        = '0;
  logic                 out_valid_o;
  logic                 out_ready_i   = 1'b1;
  logic                 hit_o;
  logic [SLOT_W-1:0]    slot_o;
  logic                 evicted_valid_o;
  logic [PAGE_BITS-1:0] evicted_page_o;
  logic [COUNT_W-1:0]   fault_count_o;
  logic [COUNT_W-1:0]   access_count_o;

  // stall tag travels with the page so the monitor knows the pause after it
  int stall_tag = 0;

  job_t         ref_jobs[$];
  ref_outcome_t outcome_q[$];

  int items_sent   = 0;
  int results_seen = 0;
  int held         = 0;
  int rx_wait      = 0;
  int cycle_count  = 0;
  int n_errors     = 0;
  int n_hits       = 0;
  int n_evicts     = 0;
  int n_cfg        = 0;

  // predicted frame table
  logic [PAGE_BITS-1:0] frame_page[FRAMES];
  int                   frame_rank[FRAMES];
  int                   n_filled;
  int                   frames_cfg;
  int                   fault_tot;
  int                   access_tot;

  lru_page_replacement dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .frames_used_i   (frames_used_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .page_i          (page_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_o           (hit_o),
    .slot_o          (slot_o),
    .evicted_valid_o (evicted_valid_o),
    .evicted_page_o  (evicted_page_o),
    .fault_count_o   (fault_count_o),
    .access_count_o  (access_count_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic log_error(string msg);
    $display("ERROR: %s", msg);
    n_errors++;
  endtask

  // four-state compare so an unknown output never slips through
  task automatic cmp_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      log_error($sformatf("result %0d: %s is %0d, expected %0d",
                          results_seen, name, got, want));
  endtask

  // Make frame s most recent; filled frames younger than limit age by one
  function automatic void refresh_rank(int s, int limit);
    int i;
    for (i = 0; i < n_filled; i++)
      if (i != s && frame_rank[i] < limit) frame_rank[i]++;
    frame_rank[s] = 0;
  endfunction

  // Look up one reference and update the frame table
  function automatic ref_outcome_t lru_predict(logic [PAGE_BITS-1:0] pg);
    ref_outcome_t o;
    int           used;
    int           slot;
    int           i;
    bit           found;
    used  = (frames_cfg < 1) ? 1 : (frames_cfg > FRAMES) ? FRAMES : frames_cfg;
    found = 1'b0;
    slot  = 0;
    o.hit      = 1'b0;
    o.ev_valid = 1'b0;
    o.ev_page  = '0;
    o.rx_stall = 0;
    if (n_filled > used) n_filled = used;
    for (i = 0; i < n_filled; i++) begin
      if (!found && frame_page[i] == pg) begin
        found = 1'b1;
        slot  = i;
      end
    end
    if (access_tot < COUNT_MAX) access_tot++;
    if (found) begin
      o.hit = 1'b1;
      refresh_rank(slot, frame_rank[slot]);
    end else begin
      if (fault_tot < COUNT_MAX) fault_tot++;
      if (n_filled < used) begin
        // free frame takes the page
        slot             = n_filled;
        frame_page[slot] = pg;
        n_filled++;
      end else begin
        // replace least recent frame, first one on a tie
        for (i = 1; i < n_filled; i++)
          if (frame_rank[i] > frame_rank[slot]) slot = i;
        o.ev_valid       = 1'b1;
        o.ev_page        = frame_page[slot];
        frame_page[slot] = pg;
      end
      refresh_rank(slot, FRAMES);
    end
    o.slot     = slot[SLOT_W-1:0];
    o.faults   = fault_tot[COUNT_W-1:0];
    o.accesses = access_tot[COUNT_W-1:0];
    return o;
  endfunction

  // Driver: presents queued jobs; config and pauses wait for an idle block
  always @(posedge clk_i or negedge rst_ni) begin : drive
    logic in_go;
    logic cfg_go;
    logic idle;
    job_t job;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
      held        <= 0;
      items_sent  <= 0;
    end else begin
      in_go  = in_valid_i && in_ready_o;
      cfg_go = cfg_valid_i && cfg_ready_o;
      idle   = !in_valid_i && !cfg_valid_i && (items_sent == results_seen);
      if (in_go) items_sent <= items_sent + 1;
      if ((in_valid_i && !in_go) || (cfg_valid_i && !cfg_go)) begin
        // transfer still pending, hold everything
      end else if (ref_jobs.size() == 0) begin
        in_valid_i  <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (held < ref_jobs[0].gap) begin
        held        <= held + 1;
        in_valid_i  <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (ref_jobs[0].kind == JOB_REF) begin
        job         = ref_jobs.pop_front();
        held        <= 0;
        in_valid_i  <= 1'b1;
        page_i      <= job.value[PAGE_BITS-1:0];
        stall_tag   <= job.stall;
        cfg_valid_i <= 1'b0;
      end else if (idle) begin
        job         = ref_jobs.pop_front();
        held        <= 0;
        in_valid_i  <= 1'b0;
        cfg_valid_i <= (job.kind == JOB_SET_FRAMES);
        if (job.kind == JOB_SET_FRAMES) frames_used_i <= job.value[CFG_W-1:0];
      end else begin
        in_valid_i  <= 1'b0;
        cfg_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks results, then applies accepted writes and references
  always @(posedge clk_i or negedge rst_ni) begin : watch
    ref_outcome_t want;
    int           pause;
    if (!rst_ni) begin
      out_ready_i  <= 1'b1;
      rx_wait      <= 0;
      results_seen <= 0;
      frames_cfg   = FRAMES_USED_RST;
      n_filled     = 0;
      fault_tot    = 0;
      access_tot   = 0;
      foreach (frame_rank[k]) begin
        frame_rank[k] = 0;
        frame_page[k] = '0;
      end
    end else begin
      pause = 0;
      if (out_valid_o && out_ready_i) begin
        results_seen <= results_seen + 1;
        if (outcome_q.size() == 0) begin
          log_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want  = outcome_q.pop_front();
          pause = want.rx_stall;
          cmp_field("hit", hit_o, want.hit);
          cmp_field("slot", slot_o, want.slot);
          cmp_field("evicted_valid", evicted_valid_o, want.ev_valid);
          cmp_field("evicted_page", evicted_page_o, want.ev_page);
          cmp_field("fault_count", fault_count_o, want.faults);
          cmp_field("access_count", access_count_o, want.accesses);
        end
        if (pause > 0) begin
          out_ready_i <= 1'b0;
          rx_wait     <= pause - 1;
        end
      end else if (!out_ready_i) begin
        if (rx_wait == 0) out_ready_i <= 1'b1;
        else rx_wait <= rx_wait - 1;
      end
      // frames_used write flushes the table, counts are kept
      if (cfg_valid_i && cfg_ready_o) begin
        frames_cfg = int'(frames_used_i);
        n_filled   = 0;
        foreach (frame_rank[k]) frame_rank[k] = 0;
        n_cfg++;
      end
      if (in_valid_i && in_ready_o) begin
        want          = lru_predict(page_i);
        want.rx_stall = stall_tag;
        n_hits       += want.hit;
        n_evicts     += want.ev_valid;
        outcome_q.push_back(want);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: no progress after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic add_ref(int pg, int gap, int stall);
    ref_jobs.push_back('{JOB_REF, pg, gap, stall});
  endtask

  task automatic add_frames(int val);
    ref_jobs.push_back('{JOB_SET_FRAMES, val, $urandom_range(0, 3), 0});
  endtask

  // Stimulus and end of run
  initial begin
    int                   n_random;
    int                   phase;
    int                   len;
    int                   used;
    int                   wsize;
    int                   gap;
    int                   stall;
    bit                   calm;
    logic [PAGE_BITS-1:0] wset[8];
    logic [PAGE_BITS-1:0] pg;

    // directed: reset setting of three frames, fill, hit, evict
    add_ref(8'h00, 0, 0);
    add_ref(8'hFF, 1, 2);
    add_ref(8'h00, 0, 0);
    add_ref(8'h80, 0, 1);
    add_ref(8'h7F, 2, 0);
    add_ref(8'hFF, 0, 0);
    add_ref(8'h80, 0, 3);
    // zero frames behaves as one frame
    add_frames(0);
    add_ref(8'h05, 0, 0);
    add_ref(8'h05, 0, 0);
    add_ref(8'h06, 1, 0);
    add_ref(8'h05, 0, 0);
    // four frames, then a value above the frame count
    add_frames(4);
    add_ref(8'h01, 0, 0);
    add_ref(8'h02, 0, 0);
    add_ref(8'h03, 0, 0);
    add_ref(8'h04, 0, 0);
    add_ref(8'h01, 0, 0);
    add_ref(8'hAA, 0, 2);
    add_ref(8'h03, 0, 0);
    add_frames(7);
    add_ref(8'h55, 0, 0);
    add_ref(8'hAA, 0, 0);
    add_ref(8'h55, 1, 0);
    add_ref(8'hFF, 0, 0);
    add_ref(8'h00, 0, 0);

    // random phases over a small working set, with some stray pages
    n_random = 0;
    phase    = 0;
    while (n_random < RAND_REFS) begin
      add_frames((phase < 8) ? phase : $urandom_range(0, 7));
      used  = (ref_jobs[$].value < 1) ? 1 :
              (ref_jobs[$].value > FRAMES) ? FRAMES : ref_jobs[$].value;
      wsize = used + $urandom_range(0, 3);
      foreach (wset[k]) wset[k] = 8'($urandom_range(0, 255));
      calm = ($urandom_range(0, 3) == 0);
      len  = $urandom_range(40, 220);
      for (int n = 0; n < len; n++) begin
        pg    = ($urandom_range(0, 99) < 85) ? wset[$urandom_range(0, wsize - 1)]
                                             : 8'($urandom_range(0, 255));
        gap   = (calm || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 11);
        stall = (calm || $urandom_range(0, 1)) ? 0 : $urandom_range(0, 11);
        add_ref(int'(pg), gap, stall);
        if ($urandom_range(0, 39) == 0) ref_jobs.push_back('{JOB_QUIESCE, 0, 0, 0});
      end
      n_random += len;
      phase++;
    end

    // one frame, every reference a fault, back to back
    add_frames(1);
    pg = 8'($urandom_range(0, 255));
    for (int n = 0; n < FAULT_REFS; n++) begin
      pg = pg + 8'($urandom_range(1, 255));
      add_ref(int'(pg), 0, 0);
    end
    add_frames(4);
    for (int n = 0; n < 16; n++)
      add_ref($urandom_range(0, 5), $urandom_range(0, 11), $urandom_range(0, 11));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(ref_jobs.size() == 0 && !in_valid_i && !cfg_valid_i &&
             items_sent == results_seen))
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (outcome_q.size() != 0)
      log_error($sformatf("%0d expected results never arrived", outcome_q.size()));

    $display("Checked %0d references: %0d hits, %0d evictions, %0d frames_used writes.",
             results_seen, n_hits, n_evicts, n_cfg);
    $display("Frame counts 0 to 7 were used, with flushes, drains, gaps and output stalls.");
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
